// File: rtl/rational_accumulator_alu_defines.svh
// assertion macros for the checker file of rational_accumulator_alu
// needs signals named clk and rst_n in the scope where a macro is used
`ifndef RATIONAL_ACCUMULATOR_ALU_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_ALU_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RAC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rac assertion failed");

// next-cycle implication, disabled during reset
`define RAC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rac assertion failed");

`endif

// File: rtl/rac_pkg.sv
// types and constants of the rational accumulator alu
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package rac_pkg;

    // bits of the multiplier operand consumed per cycle
    localparam int DIGIT_W = 4;

    typedef enum logic [2:0]
    {
        ACT_LOAD = 3'd0,
        ACT_ADD  = 3'd1,
        ACT_SUB  = 3'd2,
        ACT_MUL  = 3'd3,
        ACT_DIV  = 3'd4,
        ACT_READ = 3'd5
    } action_t;

    typedef struct packed
    {
        logic [2:0]         action;
        logic signed [31:0] operand_num;
        logic signed [31:0] operand_den;
    } cmd_t;

    typedef struct packed
    {
        logic signed [31:0] result_num;
        logic signed [31:0] result_den;
        logic               zero_den;
        logic               gcd_zero;
    } res_t;

    // multiplier operand pairs
    typedef enum logic [2:0]
    {
        MSEL_NUM_OD,
        MSEL_ON_DEN,
        MSEL_DEN_OD,
        MSEL_NUM_ON,
        MSEL_DEN_ON
    } msel_t;

    // product destinations
    typedef enum logic [1:0]
    {
        MDST_NUM,
        MDST_AUX,
        MDST_DEN
    } mdst_t;

    // divider jobs
    typedef enum logic [1:0]
    {
        DSEL_GCD,
        DSEL_NUM,
        DSEL_DEN
    } dsel_t;

    // accumulator update
    typedef enum logic [2:0]
    {
        COMMIT_NONE,
        COMMIT_LOAD,
        COMMIT_ADD,
        COMMIT_SUB,
        COMMIT_MOVE
    } commit_t;

    // result source
    typedef enum logic [1:0]
    {
        OSEL_ACC,
        OSEL_GZ,
        OSEL_RED
    } osel_t;

    typedef struct packed
    {
        logic    mul_start;
        msel_t   msel;
        mdst_t   mdst;
        logic    div_start;
        dsel_t   dsel;
        commit_t commit;
        logic    gcd_init;
        osel_t   osel;
        logic    out_load;
    } ctl_t;

    typedef struct packed
    {
        logic mul_done;
        logic div_done;
        logic a_zero;
        logic b_zero;
        logic res_free;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/rac_ctrl.sv
// sequencer of the rational accumulator alu
// depends on rac_pkg; drives the datapath through ctl_t, watches sts_t
`timescale 1ns / 1ps
`default_nettype none

module rac_ctrl
    import rac_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [2:0] action,
    input  wire sts_t       sts,
    output logic            ready,
    output ctl_t            ctl
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_DISPATCH,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_GCD_INIT,
        S_GCD_TEST,
        S_GCD_DIV,
        S_QNUM,
        S_QDEN,
        S_FINISH
    } state_t;

    state_t     state_reg;
    logic [2:0] action_reg;
    ctl_t       ctl_reg;

    assign ready = (state_reg == S_IDLE);
    assign ctl   = ctl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            action_reg <= ACT_LOAD;
            ctl_reg    <= '0;
        end
        else
        begin
            // pulses last one cycle
            ctl_reg.mul_start <= 1'b0;
            ctl_reg.div_start <= 1'b0;
            ctl_reg.commit    <= COMMIT_NONE;
            ctl_reg.gcd_init  <= 1'b0;
            ctl_reg.out_load  <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        action_reg <= action;
                        state_reg  <= S_DISPATCH;
                    end
                end

                S_DISPATCH:
                begin
                    ctl_reg.osel <= OSEL_ACC;
                    case (action_reg)
                        ACT_LOAD:
                        begin
                            ctl_reg.commit <= COMMIT_LOAD;
                            state_reg      <= S_FINISH;
                        end
                        ACT_ADD, ACT_SUB, ACT_DIV:
                        begin
                            ctl_reg.mul_start <= 1'b1;
                            ctl_reg.msel      <= MSEL_NUM_OD;
                            ctl_reg.mdst      <= MDST_NUM;
                            state_reg         <= S_MUL1;
                        end
                        ACT_MUL:
                        begin
                            ctl_reg.mul_start <= 1'b1;
                            ctl_reg.msel      <= MSEL_NUM_ON;
                            ctl_reg.mdst      <= MDST_NUM;
                            state_reg         <= S_MUL1;
                        end
                        ACT_READ:
                        begin
                            ctl_reg.gcd_init <= 1'b1;
                            state_reg        <= S_GCD_INIT;
                        end
                        default:
                        begin
                            // unused codes return the stored fraction
                            state_reg <= S_FINISH;
                        end
                    endcase
                end

                S_MUL1:
                begin
                    if (sts.mul_done)
                    begin
                        ctl_reg.mul_start <= 1'b1;
                        case (action_reg)
                            ACT_ADD, ACT_SUB:
                            begin
                                ctl_reg.msel <= MSEL_ON_DEN;
                                ctl_reg.mdst <= MDST_AUX;
                            end
                            ACT_MUL:
                            begin
                                ctl_reg.msel <= MSEL_DEN_OD;
                                ctl_reg.mdst <= MDST_DEN;
                            end
                            default:
                            begin
                                ctl_reg.msel <= MSEL_DEN_ON;
                                ctl_reg.mdst <= MDST_DEN;
                            end
                        endcase
                        state_reg <= S_MUL2;
                    end
                end

                S_MUL2:
                begin
                    if (sts.mul_done)
                    begin
                        if (action_reg inside {ACT_ADD, ACT_SUB})
                        begin
                            ctl_reg.mul_start <= 1'b1;
                            ctl_reg.msel      <= MSEL_DEN_OD;
                            ctl_reg.mdst      <= MDST_DEN;
                            state_reg         <= S_MUL3;
                        end
                        else
                        begin
                            ctl_reg.commit <= COMMIT_MOVE;
                            state_reg      <= S_FINISH;
                        end
                    end
                end

                S_MUL3:
                begin
                    if (sts.mul_done)
                    begin
                        ctl_reg.commit <= (action_reg == ACT_SUB) ? COMMIT_SUB : COMMIT_ADD;
                        state_reg      <= S_FINISH;
                    end
                end

                S_GCD_INIT:
                begin
                    state_reg <= S_GCD_TEST;
                end

                S_GCD_TEST:
                begin
                    if (sts.b_zero)
                    begin
                        if (sts.a_zero)
                        begin
                            ctl_reg.osel <= OSEL_GZ;
                            state_reg    <= S_FINISH;
                        end
                        else
                        begin
                            ctl_reg.div_start <= 1'b1;
                            ctl_reg.dsel      <= DSEL_NUM;
                            state_reg         <= S_QNUM;
                        end
                    end
                    else
                    begin
                        ctl_reg.div_start <= 1'b1;
                        ctl_reg.dsel      <= DSEL_GCD;
                        state_reg         <= S_GCD_DIV;
                    end
                end

                S_GCD_DIV:
                begin
                    if (sts.div_done)
                    begin
                        state_reg <= S_GCD_TEST;
                    end
                end

                S_QNUM:
                begin
                    if (sts.div_done)
                    begin
                        ctl_reg.div_start <= 1'b1;
                        ctl_reg.dsel      <= DSEL_DEN;
                        state_reg         <= S_QDEN;
                    end
                end

                S_QDEN:
                begin
                    if (sts.div_done)
                    begin
                        ctl_reg.osel <= OSEL_RED;
                        state_reg    <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    if (sts.res_free)
                    begin
                        ctl_reg.out_load <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/rac_dpath.sv
// datapath of the rational accumulator alu: accumulator, digit-serial
// multiplier, restoring divider, euclid registers, result register
// depends on rac_pkg; commanded by rac_ctrl
`timescale 1ns / 1ps
`default_nettype none

module rac_dpath
    import rac_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic capture,
    input  wire cmd_t cmd,
    input  wire ctl_t ctl,
    input  wire logic res_ready,
    output logic      res_valid,
    output res_t      res,
    output sts_t      sts
);

    localparam int EXT_W  = (WIDTH > 32) ? WIDTH : 32;
    localparam int NDIG   = (WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int MCNT_W = $clog2(NDIG);
    localparam int DCNT_W = $clog2(WIDTH);

    function automatic logic [WIDTH-1:0] mag_w(input logic [WIDTH-1:0] v);
        return v[WIDTH-1] ? -v : v;
    endfunction

    // operands and accumulator
    logic signed [EXT_W-1:0] on_ext;
    logic signed [EXT_W-1:0] od_ext;
    logic [WIDTH-1:0]        op_num_reg;
    logic [WIDTH-1:0]        op_den_reg;
    logic [WIDTH-1:0]        acc_num_reg;
    logic [WIDTH-1:0]        acc_den_reg;
    logic [WIDTH-1:0]        p_num_reg;
    logic [WIDTH-1:0]        p_aux_reg;
    logic [WIDTH-1:0]        p_den_reg;

    assign on_ext = EXT_W'(cmd.operand_num);
    assign od_ext = EXT_W'(cmd.operand_den);

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            op_num_reg <= on_ext[WIDTH-1:0];
            op_den_reg <= od_ext[WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= WIDTH'(1);
        end
        else
        begin
            case (ctl.commit)
                COMMIT_LOAD:
                begin
                    acc_num_reg <= op_num_reg;
                    acc_den_reg <= op_den_reg;
                end
                COMMIT_ADD:
                begin
                    acc_num_reg <= p_num_reg + p_aux_reg;
                    acc_den_reg <= p_den_reg;
                end
                COMMIT_SUB:
                begin
                    acc_num_reg <= p_num_reg - p_aux_reg;
                    acc_den_reg <= p_den_reg;
                end
                COMMIT_MOVE:
                begin
                    acc_num_reg <= p_num_reg;
                    acc_den_reg <= p_den_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // multiplier, one digit of b per cycle, product wraps at WIDTH bits
    logic [WIDTH-1:0]         mul_sel_a;
    logic [WIDTH-1:0]         mul_sel_b;
    logic                     mul_busy_reg;
    logic [MCNT_W-1:0]        mul_cnt_reg;
    logic [WIDTH-1:0]         mul_a_reg;
    logic [WIDTH-1:0]         mul_b_reg;
    logic [WIDTH-1:0]         mul_sum_reg;
    mdst_t                    mul_dst_reg;
    logic [WIDTH+DIGIT_W-1:0] mul_pp;
    logic [WIDTH-1:0]         mul_acc;
    logic                     mul_last;

    always_comb
    begin
        case (ctl.msel)
            MSEL_NUM_OD: begin mul_sel_a = acc_num_reg; mul_sel_b = op_den_reg; end
            MSEL_ON_DEN: begin mul_sel_a = op_num_reg;  mul_sel_b = acc_den_reg; end
            MSEL_DEN_OD: begin mul_sel_a = acc_den_reg; mul_sel_b = op_den_reg; end
            MSEL_NUM_ON: begin mul_sel_a = acc_num_reg; mul_sel_b = op_num_reg; end
            MSEL_DEN_ON: begin mul_sel_a = acc_den_reg; mul_sel_b = op_num_reg; end
            default:     begin mul_sel_a = acc_num_reg; mul_sel_b = op_den_reg; end
        endcase
    end

    assign mul_pp   = mul_a_reg * mul_b_reg[DIGIT_W-1:0];
    assign mul_acc  = mul_sum_reg + mul_pp[WIDTH-1:0];
    assign mul_last = mul_busy_reg && (mul_cnt_reg == MCNT_W'(NDIG - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else if (ctl.mul_start)
        begin
            mul_busy_reg <= 1'b1;
            mul_cnt_reg  <= '0;
        end
        else if (mul_busy_reg)
        begin
            mul_cnt_reg <= mul_cnt_reg + 1'b1;
            if (mul_last)
            begin
                mul_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_start)
        begin
            mul_a_reg   <= mul_sel_a;
            mul_b_reg   <= mul_sel_b;
            mul_sum_reg <= '0;
            mul_dst_reg <= ctl.mdst;
        end
        else if (mul_busy_reg)
        begin
            mul_a_reg   <= mul_a_reg << DIGIT_W;
            mul_b_reg   <= mul_b_reg >> DIGIT_W;
            mul_sum_reg <= mul_acc;
        end
        if (mul_last)
        begin
            case (mul_dst_reg)
                MDST_NUM: p_num_reg <= mul_acc;
                MDST_AUX: p_aux_reg <= mul_acc;
                MDST_DEN: p_den_reg <= mul_acc;
                default:  p_aux_reg <= mul_acc;
            endcase
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [WIDTH-1:0]  div_sel_n;
    logic [WIDTH-1:0]  div_sel_d;
    logic              div_busy_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [WIDTH-1:0]  div_quo_reg;
    logic [WIDTH-1:0]  div_rem_reg;
    logic [WIDTH-1:0]  div_dvs_reg;
    dsel_t             div_job_reg;
    logic [WIDTH:0]    div_sh;
    logic [WIDTH:0]    div_diff;
    logic              div_ge;
    logic [WIDTH-1:0]  div_rem_nx;
    logic [WIDTH-1:0]  div_quo_nx;
    logic              div_last;

    // euclid pair and quotients
    logic [WIDTH-1:0]  gcd_a_reg;
    logic [WIDTH-1:0]  gcd_b_reg;
    logic [WIDTH-1:0]  qn_reg;
    logic [WIDTH-1:0]  qd_reg;

    always_comb
    begin
        case (ctl.dsel)
            DSEL_GCD: begin div_sel_n = gcd_a_reg;          div_sel_d = gcd_b_reg; end
            DSEL_NUM: begin div_sel_n = mag_w(acc_num_reg); div_sel_d = gcd_a_reg; end
            DSEL_DEN: begin div_sel_n = mag_w(acc_den_reg); div_sel_d = gcd_a_reg; end
            default:  begin div_sel_n = gcd_a_reg;          div_sel_d = gcd_b_reg; end
        endcase
    end

    assign div_sh     = {div_rem_reg, div_quo_reg[WIDTH-1]};
    assign div_diff   = div_sh - {1'b0, div_dvs_reg};
    assign div_ge     = (div_sh >= {1'b0, div_dvs_reg});
    assign div_rem_nx = div_ge ? div_diff[WIDTH-1:0] : div_sh[WIDTH-1:0];
    assign div_quo_nx = {div_quo_reg[WIDTH-2:0], div_ge};
    assign div_last   = div_busy_reg && (div_cnt_reg == DCNT_W'(WIDTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (ctl.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_last)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            div_quo_reg <= div_sel_n;
            div_rem_reg <= '0;
            div_dvs_reg <= div_sel_d;
            div_job_reg <= ctl.dsel;
        end
        else if (div_busy_reg)
        begin
            div_quo_reg <= div_quo_nx;
            div_rem_reg <= div_rem_nx;
        end

        if (ctl.gcd_init)
        begin
            gcd_a_reg <= mag_w(acc_num_reg);
            gcd_b_reg <= mag_w(acc_den_reg);
        end
        else if (div_last && (div_job_reg == DSEL_GCD))
        begin
            gcd_a_reg <= gcd_b_reg;
            gcd_b_reg <= div_rem_nx;
        end

        if (div_last && (div_job_reg == DSEL_NUM))
        begin
            qn_reg <= div_quo_nx;
        end
        if (div_last && (div_job_reg == DSEL_DEN))
        begin
            qd_reg <= div_quo_nx;
        end
    end

    // reduced fraction: signs back on, then both negated if the denominator is negative
    logic [WIDTH-1:0] red_num1;
    logic [WIDTH-1:0] red_den1;
    logic [WIDTH-1:0] red_num;
    logic [WIDTH-1:0] red_den;

    assign red_num1 = acc_num_reg[WIDTH-1] ? -qn_reg : qn_reg;
    assign red_den1 = acc_den_reg[WIDTH-1] ? -qd_reg : qd_reg;
    assign red_num  = red_den1[WIDTH-1] ? -red_num1 : red_num1;
    assign red_den  = red_den1[WIDTH-1] ? -red_den1 : red_den1;

    // result register
    logic [WIDTH-1:0]        out_num_w;
    logic [WIDTH-1:0]        out_den_w;
    logic signed [EXT_W-1:0] out_num_ext;
    logic signed [EXT_W-1:0] out_den_ext;
    logic                    res_valid_reg;
    res_t                    res_reg;

    assign out_num_w   = (ctl.osel == OSEL_RED) ? red_num : acc_num_reg;
    assign out_den_w   = (ctl.osel == OSEL_RED) ? red_den : acc_den_reg;
    assign out_num_ext = EXT_W'($signed(out_num_w));
    assign out_den_ext = EXT_W'($signed(out_den_w));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res_reg.result_num <= out_num_ext[31:0];
            res_reg.result_den <= out_den_ext[31:0];
            res_reg.zero_den   <= (out_den_w == '0);
            res_reg.gcd_zero   <= (ctl.osel == OSEL_GZ);
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign sts.mul_done = mul_last;
    assign sts.div_done = div_last;
    assign sts.a_zero   = (gcd_a_reg == '0);
    assign sts.b_zero   = (gcd_b_reg == '0);
    assign sts.res_free = !res_valid_reg || res_ready;

endmodule

`default_nettype wire

// File: rtl/rational_accumulator_alu.sv
// work per command: load none, add/sub three multiplies, mul/div two, all on
// the digit-serial multiplier with 4-bit digits; read: euclid's loop of divides,
// then the two final divides unless the fraction is 0/0, on the one-bit-per-cycle
// divider; one item in flight, next cmd beat taken while res waits
// reset: asynchronous active-low rst_n, fraction returns to 0/1, no result pending
`timescale 1ns / 1ps
`default_nettype none

module rational_accumulator_alu
    import rac_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic clk,
    input  wire logic rst_n,

    // command channel: action plus operand fraction
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire cmd_t cmd,

    // result channel: one beat per command
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res
);

    // the controller walks each command through its multiplies or through
    // euclid's loop and the two final divides; the datapath owns all
    // arithmetic, the accumulator and the result register
    ctl_t ctl;
    sts_t sts;
    logic cmd_accept;

    assign cmd_accept = cmd_valid && cmd_ready;

    rac_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (cmd_accept),
        .action (cmd.action),
        .sts    (sts),
        .ready  (cmd_ready),
        .ctl    (ctl)
    );

    // operands are sign-extended and latched on the accepted beat, so the
    // command payload may change right after
    rac_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (cmd_accept),
        .cmd       (cmd),
        .ctl       (ctl),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// File: rtl/rac_checker.sv
// port-level checks of rational_accumulator_alu, bound to the top level
// depends on rac_pkg and rational_accumulator_alu_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "rational_accumulator_alu_defines.svh"

module rac_checker
    import rac_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cmd_valid,
    input wire logic cmd_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res
);

    // a stalled result beat holds
    `RAC_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

    // one command in flight at a time
    `RAC_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready)

    // unreduced 0/0 read
    `RAC_ASSERT_IMPL(a_gcd_zero_parts, res_valid && res.gcd_zero, res.zero_den && res.result_num == 0 && res.result_den == 0)

    // a result only appears after the block was busy
    `RAC_ASSERT_IMPL(a_res_from_work, $rose(res_valid), $past(!cmd_ready, 2))

endmodule

bind rational_accumulator_alu rac_checker u_rac_checker (.*);

`default_nettype wire

// File: tb/sv/rational_accumulator_alu_test.sv
// self-checking testbench for rational_accumulator_alu: directed and random command beats
// depends on rac_pkg (cmd_t, res_t, action_t) and the rational_accumulator_alu rtl
`timescale 1ns / 1ps

module rational_accumulator_alu_test;
    import rac_pkg::*;

    // codes the block does not define: state is kept and the fraction comes back as is
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS   = 1800;
    localparam int SETTLE_CYCLES  = 200;   // quiet time after the last result

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    // predicted fraction, same wrap-around widths as the block
    logic [31:0] frac_num = 32'd0;
    logic [31:0] frac_den = 32'd1;
    res_t pending_results[$];

    int mismatch_count = 0;
    int beats_sent = 0;
    int reads_sent = 0;
    int spare_sent = 0;
    int results_checked = 0;
    int zero_den_seen = 0;
    int gcd_zero_seen = 0;
    int burst_left = 0;

    rational_accumulator_alu #(.WIDTH(32)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction: apply one command to the predicted fraction
    // ------------------------------------------------------------------
    function automatic res_t step_fraction(input cmd_t c);
        logic [31:0] on;
        logic [31:0] od;
        logic [31:0] rn;
        logic [31:0] rd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic        gz;
        res_t        r;
        on = c.operand_num;
        od = c.operand_den;
        gz = 1'b0;
        // cross-multiply without reduction, every product wraps at 32 bits;
        // numerator first so it still sees the old denominator
        case (c.action)
            ACT_LOAD:
            begin
                frac_num = on;
                frac_den = od;
            end
            ACT_ADD:
            begin
                frac_num = frac_num * od + on * frac_den;
                frac_den = frac_den * od;
            end
            ACT_SUB:
            begin
                frac_num = frac_num * od - on * frac_den;
                frac_den = frac_den * od;
            end
            ACT_MUL:
            begin
                frac_num = frac_num * on;
                frac_den = frac_den * od;
            end
            ACT_DIV:
            begin
                frac_num = frac_num * od;
                frac_den = frac_den * on;
            end
            default:
            begin
            end
        endcase
        rn = frac_num;
        rd = frac_den;
        if (c.action == ACT_READ)
        begin
            // euclid on the magnitudes; the most negative value has magnitude 2^31
            a = rn[31] ? -rn : rn;
            b = rd[31] ? -rd : rd;
            while (b != 32'd0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            if (a == 32'd0)
                gz = 1'b1;
            else
            begin
                // truncating signed quotient by the gcd
                rn = rn[31] ? -((-rn) / a) : rn / a;
                rd = rd[31] ? -((-rd) / a) : rd / a;
                // sign to the numerator; a most negative denominator stays negative
                if (rd[31])
                begin
                    rn = -rn;
                    rd = -rd;
                end
            end
        end
        r.result_num = rn;
        r.result_den = rd;
        r.zero_den = (rd == 32'd0);
        r.gcd_zero = gz;
        return r;
    endfunction

    // every accepted command beat queues its one predicted result
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
            pending_results.push_back(step_fraction(cmd));
    end

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s at result %0d: got %h, predicted %h",
                 $time, what, results_checked, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending", res.result_num, '0);
            else
            begin
                want = pending_results.pop_front();
                if (res.result_num !== want.result_num)
                    report_mismatch("result_num", res.result_num, want.result_num);
                if (res.result_den !== want.result_den)
                    report_mismatch("result_den", res.result_den, want.result_den);
                if (res.zero_den !== want.zero_den)
                    report_mismatch("zero_den", res.zero_den, want.zero_den);
                if (res.gcd_zero !== want.gcd_zero)
                    report_mismatch("gcd_zero", res.gcd_zero, want.gcd_zero);
                zero_den_seen += want.zero_den;
                gcd_zero_seen += want.gcd_zero;
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // result side back-pressure: modes of random length, from always
    // ready through light and heavy stalling to long holds
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       res_ready <= 1'b1;
            1:       res_ready <= 1'($urandom_range(0, 1));
            2:       res_ready <= ($urandom_range(0, 3) == 0);
            default: res_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // one command beat; bursts of random length separated by random gaps.
    // returns at the edge that took the beat, valid still high
    task automatic send_cmd(input logic [2:0] act, input logic [31:0] num,
                            input logic [31:0] den);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd <= '{action: act, operand_num: num, operand_den: den};
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        beats_sent++;
        if (act == ACT_READ)
            reads_sent++;
        if (act == ACT_SPARE_A || act == ACT_SPARE_B)
            spare_sent++;
    endtask

    // hold off new commands until every predicted result has come back;
    // the last accepted beat is queued before the check begins
    task automatic drain_results();
        cmd_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // operand mix: small values most often so reductions find real common factors,
    // plus mid-range, full-width and the corner values
    function automatic logic [31:0] pick_operand(input bit allow_zero);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 40) - 20;
            4, 5:       v = $urandom_range(0, 8190) - 4095;
            6, 7, 8:    v = $urandom();
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h0000_0001;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
        endcase
        if (!allow_zero && v == 32'd0)
            v = 32'd1;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // fraction after reset is 0/1; unused codes hand it back untouched
    task automatic test_reset_state();
        send_cmd(ACT_READ, 32'd0, 32'd0);
        send_cmd(ACT_SPARE_A, $urandom(), $urandom());
        send_cmd(ACT_SPARE_B, $urandom(), $urandom());
        drain_results();
    endtask

    // reductions of the awkward fractions
    task automatic test_special_reads();
        // 0/0: no reduction possible
        send_cmd(ACT_LOAD, 32'd0, 32'd0);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        // nonzero over zero reduces to unit over zero
        send_cmd(ACT_LOAD, -32'sd7, 32'd0);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        // zero over nonzero reduces to 0/1
        send_cmd(ACT_LOAD, 32'd0, -32'sd5);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        // most negative denominator cannot be negated and stays negative
        send_cmd(ACT_LOAD, 32'd3, 32'h8000_0000);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        send_cmd(ACT_LOAD, 32'h8000_0000, 32'h8000_0000);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        // consecutive fibonacci numbers: the longest euclid run at 32 bits
        send_cmd(ACT_LOAD, 32'd1836311903, -32'sd1134903170);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        // largest positive over a negative unit
        send_cmd(ACT_LOAD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        drain_results();
    endtask

    // each operation, wrap-around products, divide by a zero operand
    task automatic test_arithmetic();
        send_cmd(ACT_LOAD, 32'd1, 32'd2);
        send_cmd(ACT_ADD, 32'd1, 32'd3);
        send_cmd(ACT_SUB, -32'sd5, 32'd7);
        send_cmd(ACT_MUL, 32'h7FFF_FFFF, 32'd3);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        send_cmd(ACT_DIV, 32'd0, 32'd4);
        send_cmd(ACT_READ, 32'd0, 32'd0);
        send_cmd(ACT_SPARE_B, 32'hFFFF_FFFF, 32'h8000_0000);
        drain_results();
    endtask

    // random sequences: load, a few operations, then usually a reduced read;
    // about one in ten is noise with any code and raw operand bits
    task automatic test_random_sequences();
        int sent;
        int ops;
        int sequences;
        sent = 0;
        sequences = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                ops = $urandom_range(1, 3);
                repeat (ops)
                begin
                    send_cmd(3'($urandom_range(ACT_LOAD, ACT_SPARE_B)),
                             $urandom(), $urandom());
                    sent++;
                end
            end
            else
            begin
                send_cmd(ACT_LOAD, pick_operand(1'b1),
                         pick_operand($urandom_range(0, 19) == 0));
                sent++;
                ops = $urandom_range(1, 5);
                repeat (ops)
                begin
                    send_cmd(action_t'($urandom_range(ACT_ADD, ACT_DIV)),
                             pick_operand($urandom_range(0, 9) == 0),
                             pick_operand($urandom_range(0, 19) == 0));
                    sent++;
                end
                if ($urandom_range(0, 99) < 85)
                begin
                    send_cmd(ACT_READ, $urandom(), $urandom());
                    sent++;
                end
            end
            // now and then let the pipeline run completely dry
            sequences++;
            if (sequences % 37 == 0)
                drain_results();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_special_reads();
        test_arithmetic();
        test_random_sequences();

        // nothing pending; stay a while to catch stray result beats
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d command beats: %0d reduced reads, %0d unused codes, %0d checked",
                 beats_sent, reads_sent, spare_sent, results_checked);
        $display("zero denominators returned %0d times, unreducible 0/0 %0d times",
                 zero_den_seen, gcd_zero_seen);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // guard against a hung handshake; well beyond the slowest legal run
    initial
    begin
        #120_000_000;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
